### hw/rtl/ppsa_pkg.sv
`timescale 1ns / 1ps

package ppsa_pkg;

	localparam int MAG_W = 61;
	localparam logic [MAG_W-1:0] MAG_CAP = '1;

	typedef struct packed {
		logic        func;
		logic        last;
		logic        skip;
		logic [31:0] ta_mag;
		logic        ta_neg;
		logic [31:0] tb_mag;
		logic        tb_neg;
		logic [31:0] p_mag;
		logic [31:0] w_mag;
		logic        w_neg;
		logic [31:0] m1_mag;
		logic [31:0] m2_mag;
		logic        m_neg;
	} term_t;

endpackage

### hw/rtl/ppsa_front.sv
`timescale 1ns / 1ps

module ppsa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic signed [31:0]  freq_a,
	input  logic signed [31:0]  freq_b,
	input  logic signed [31:0]  band_energy,
	input  logic                occupied,
	input  logic signed [31:0]  pole_freq,
	input  logic signed [31:0]  pole_weight,
	input  logic signed [31:0]  elem_a,
	input  logic signed [31:0]  elem_b,
	input  logic                last,
	input  logic                take,
	output logic                avail,
	output ppsa_pkg::term_t     ent
);

	// Returns {negative, magnitude} of f - e +/- w clamped to the signed 32-bit range.
	function automatic logic [32:0] shifted_t(input logic signed [31:0] f,
		input logic signed [31:0] e, input logic signed [31:0] w, input logic occ);
		logic signed [33:0] t;
		logic signed [33:0] tabs;
		logic [32:0] res;
		t = 34'(f) - 34'(e) + (occ ? 34'(w) : -34'(w));
		tabs = t[33] ? -t : t;
		if (t > 34'sd2147483647) begin
			res = {1'b0, 32'h7FFF_FFFF};
		end else if (t < -34'sd2147483648) begin
			res = {1'b1, 32'h8000_0000};
		end else begin
			res = {t[33], tabs[31:0]};
		end
		return res;
	endfunction

	ppsa_pkg::term_t mem_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	ppsa_pkg::term_t new_ent;
	logic [32:0]     ta;
	logic [32:0]     tb;
	logic            do_push;
	logic            do_take;

	always_comb begin
		ta = shifted_t(freq_a, band_energy, pole_freq, occupied);
		tb = shifted_t(freq_b, band_energy, pole_freq, occupied);
		new_ent.func   = func;
		new_ent.last   = last;
		new_ent.skip   = pole_weight[31] || (pole_weight == 32'sd0);
		new_ent.ta_mag = ta[31:0];
		new_ent.ta_neg = ta[32];
		new_ent.tb_mag = tb[31:0];
		new_ent.tb_neg = tb[32];
		new_ent.p_mag  = pole_weight;
		new_ent.w_mag  = pole_freq[31] ? -pole_freq : pole_freq;
		new_ent.w_neg  = pole_freq[31];
		new_ent.m1_mag = elem_a[31] ? -elem_a : elem_a;
		new_ent.m2_mag = elem_b[31] ? -elem_b : elem_b;
		new_ent.m_neg  = elem_a[31] ^ elem_b[31];
	end

	assign full    = cnt_q[1];
	assign avail   = (cnt_q != 2'd0);
	assign ent     = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_take);
		end
	end

endmodule

### hw/rtl/ppsa_mul.sv
`timescale 1ns / 1ps

module ppsa_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic         busy_q;
	logic [2:0]   cnt_q;
	logic [63:0]  pp_q;
	logic [1:0]   off_q;
	logic         ppv_q;
	logic [127:0] acc_q;
	logic         done_q;
	logic [31:0]  a_part;
	logic [31:0]  b_part;
	logic [127:0] addend;

	always_comb begin
		a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		unique case (off_q)
			2'd0:    addend = {64'd0, pp_q};
			2'd1:    addend = {32'd0, pp_q, 32'd0};
			default: addend = {pp_q, 64'd0};
		endcase
	end

	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pp_q   <= '0;
			off_q  <= '0;
			ppv_q  <= 1'b0;
			acc_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				cnt_q  <= '0;
				ppv_q  <= 1'b0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					pp_q  <= a_part * b_part;
					off_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
					ppv_q <= 1'b1;
				end
				if (ppv_q) begin
					acc_q <= acc_q + addend;
				end
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

endmodule

### hw/rtl/ppsa_div.sv
`timescale 1ns / 1ps

module ppsa_div #(
	parameter int FRAC_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [62:0]                   a,
	input  logic                          sh_full,
	input  logic [62:0]                   d,
	output logic                          done,
	output logic [ppsa_pkg::MAG_W-1:0]    q
);

	logic [62:0]  d_q;
	logic [62:0]  r_q;
	logic [62:0]  lo_q;
	logic [62:0]  q_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [127:0] num;
	logic [64:0]  hi;
	logic [63:0]  r2;
	logic         ge;

	always_comb begin
		num = sh_full ? ({65'd0, a} << (2 * FRAC_BITS)) : ({65'd0, a} << FRAC_BITS);
		hi  = num[127:63];
		r2  = {r_q, lo_q[62]};
		ge  = (r2 >= {1'b0, d_q});
	end

	assign done = done_q;
	assign q    = (q_q[62] || q_q[61]) ? ppsa_pkg::MAG_CAP : q_q[60:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q    <= '0;
			r_q    <= '0;
			lo_q   <= '0;
			q_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				d_q <= d;
				if (d == 63'd0) begin
					q_q    <= '0;
					done_q <= 1'b1;
				end else if (hi >= {2'b00, d}) begin
					q_q    <= '1;
					done_q <= 1'b1;
				end else begin
					r_q    <= hi[62:0];
					lo_q   <= num[62:0];
					q_q    <= '0;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				r_q  <= ge ? 63'(r2 - {1'b0, d_q}) : r2[62:0];
				q_q  <= {q_q[61:0], ge};
				lo_q <= {lo_q[61:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd62) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/ppsa_back.sv
`timescale 1ns / 1ps

module ppsa_back #(
	parameter int FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [30:0]         eta,
	input  logic                avail,
	input  ppsa_pkg::term_t     ent,
	output logic                take,
	output logic                res_valid,
	input  logic                res_pop,
	output logic signed [31:0]  sigma_value,
	output logic signed [31:0]  sigma_slope,
	output logic                saturated
);

	typedef enum logic [3:0] {
		S_IDLE, S_ETA, S_MM, S_PWM, S_TSQ, S_DIVU,
		S_MULX, S_MULY, S_DIVR, S_DIVV, S_DONE
	} state_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] acc,
		input logic signed [63:0] t);
		logic signed [64:0] s;
		logic signed [63:0] res;
		s = 65'(acc) + 65'(t);
		if (s[64] != s[63]) begin
			res = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			res = s[63:0];
		end
		return res;
	endfunction

	// Returns {clipped, value} with the value limited to the signed 32-bit range.
	function automatic logic [32:0] clip32(input logic signed [63:0] v);
		logic [32:0] res;
		if ((v[63:31] != '0) && (v[63:31] != '1)) begin
			res = {1'b1, v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		end else begin
			res = {1'b0, v[31:0]};
		end
		return res;
	endfunction

	state_t                        state_q;
	logic                          issued_q;
	ppsa_pkg::term_t               ent_q;
	logic                          tsel_q;
	logic                          slope_q;
	logic [61:0]                   eta2_q;
	logic [63:0]                   mm_q;
	logic [63:0]                   pwm_q;
	logic [62:0]                   t2_q;
	logic signed [63:0]            s_q;
	logic [ppsa_pkg::MAG_W-1:0]    x_q;
	logic [ppsa_pkg::MAG_W-1:0]    r_q;
	logic [ppsa_pkg::MAG_W-1:0]    v_q;
	logic signed [63:0]            value_sum_q;
	logic signed [63:0]            slope_sum_q;
	logic                          res_valid_q;
	logic signed [31:0]            value_q;
	logic signed [31:0]            slope_q_out;
	logic                          sat_q;

	logic [62:0]                   d;
	logic [62:0]                   dm;
	logic [31:0]                   t_mag;
	logic                          t_neg;
	logic [63:0]                   s_abs;
	logic [63:0]                   mul_a;
	logic [63:0]                   mul_b;
	logic                          mul_start;
	logic                          mul_done;
	logic [127:0]                  mul_prod;
	logic [62:0]                   div_a;
	logic                          div_sh;
	logic                          div_start;
	logic                          div_done;
	logic [ppsa_pkg::MAG_W-1:0]    div_q;
	logic [127:0]                  prod_sh;
	logic [ppsa_pkg::MAG_W-1:0]    prod_cap;
	logic signed [63:0]            u_signed;
	logic                          term_neg;
	logic signed [63:0]            term;
	logic [32:0]                   clip_v;
	logic [32:0]                   clip_s;
	logic                          emit;

	always_comb begin
		d        = t2_q + 63'(eta2_q);
		dm       = (63'(eta2_q) >= t2_q) ? 63'(eta2_q) - t2_q : t2_q - 63'(eta2_q);
		t_mag    = tsel_q ? ent_q.tb_mag : ent_q.ta_mag;
		t_neg    = tsel_q ? ent_q.tb_neg : ent_q.ta_neg;
		s_abs    = s_q[63] ? 64'(-s_q) : 64'(s_q);
		u_signed = t_neg ? -64'(div_q) : 64'(div_q);

		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ETA: begin
				mul_a = 64'(eta);
				mul_b = 64'(eta);
			end
			S_MM: begin
				mul_a = 64'(ent_q.m1_mag);
				mul_b = ent_q.func ? 64'(ent_q.m2_mag) : 64'(ent_q.m1_mag);
			end
			S_PWM: begin
				mul_a = 64'(ent_q.p_mag);
				mul_b = 64'(ent_q.w_mag);
			end
			S_TSQ: begin
				mul_a = 64'(t_mag);
				mul_b = 64'(t_mag);
			end
			S_MULX: begin
				mul_a = slope_q ? 64'(v_q) : s_abs;
				mul_b = mm_q;
			end
			S_MULY: begin
				mul_a = 64'(x_q);
				mul_b = pwm_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		div_a  = 63'(t_mag);
		div_sh = 1'b1;
		unique case (state_q)
			S_DIVR: begin
				div_a  = dm;
				div_sh = 1'b0;
			end
			S_DIVV: begin
				div_a  = 63'(r_q);
				div_sh = 1'b1;
			end
			default: begin
				div_a  = 63'(t_mag);
				div_sh = 1'b1;
			end
		endcase

		mul_start = !issued_q && ((state_q == S_ETA) || (state_q == S_MM) ||
			(state_q == S_PWM) || (state_q == S_TSQ) || (state_q == S_MULX) ||
			(state_q == S_MULY));
		div_start = !issued_q && ((state_q == S_DIVU) || (state_q == S_DIVR) ||
			(state_q == S_DIVV));

		if (state_q == S_MULX) begin
			prod_sh = mul_prod >> (2 * FRAC_BITS);
		end else if (ent_q.func) begin
			prod_sh = mul_prod >> (2 * FRAC_BITS + 2);
		end else begin
			prod_sh = mul_prod >> (2 * FRAC_BITS + 1);
		end
		prod_cap = (prod_sh[127:61] != '0) ? ppsa_pkg::MAG_CAP : prod_sh[60:0];

		term_neg = slope_q ? ((t2_q > 63'(eta2_q)) ^ ent_q.w_neg)
			: (s_q[63] ^ (ent_q.func & ent_q.m_neg) ^ ent_q.w_neg);
		term     = term_neg ? -64'(prod_cap) : 64'(prod_cap);

		clip_v = clip32(value_sum_q);
		clip_s = clip32(slope_sum_q);
		emit   = (state_q == S_DONE) && ent_q.last && !res_valid_q;
	end

	assign take        = (state_q == S_IDLE) && avail;
	assign res_valid   = res_valid_q;
	assign sigma_value = value_q;
	assign sigma_slope = slope_q_out;
	assign saturated   = sat_q;

	ppsa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ppsa_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.a       (div_a),
		.sh_full (div_sh),
		.d       (d),
		.done    (div_done),
		.q       (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			ent_q       <= '0;
			tsel_q      <= 1'b0;
			slope_q     <= 1'b0;
			eta2_q      <= '0;
			mm_q        <= '0;
			pwm_q       <= '0;
			t2_q        <= '0;
			s_q         <= '0;
			x_q         <= '0;
			r_q         <= '0;
			v_q         <= '0;
			value_sum_q <= '0;
			slope_sum_q <= '0;
			res_valid_q <= 1'b0;
			value_q     <= '0;
			slope_q_out <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (avail) begin
						ent_q   <= ent;
						tsel_q  <= 1'b0;
						slope_q <= 1'b0;
						state_q <= ent.skip ? S_DONE : S_ETA;
					end
				end
				S_ETA: begin
					if (mul_done) begin
						eta2_q   <= mul_prod[61:0];
						issued_q <= 1'b0;
						state_q  <= S_MM;
					end
				end
				S_MM: begin
					if (mul_done) begin
						mm_q     <= mul_prod[63:0];
						issued_q <= 1'b0;
						state_q  <= S_PWM;
					end
				end
				S_PWM: begin
					if (mul_done) begin
						pwm_q    <= mul_prod[63:0];
						issued_q <= 1'b0;
						state_q  <= S_TSQ;
					end
				end
				S_TSQ: begin
					if (mul_done) begin
						t2_q     <= mul_prod[62:0];
						issued_q <= 1'b0;
						state_q  <= S_DIVU;
					end
				end
				S_DIVU: begin
					if (div_done) begin
						issued_q <= 1'b0;
						if (ent_q.func && !tsel_q) begin
							s_q     <= u_signed;
							tsel_q  <= 1'b1;
							state_q <= S_TSQ;
						end else begin
							s_q     <= (ent_q.func) ? s_q + u_signed : u_signed;
							state_q <= S_MULX;
						end
					end
				end
				S_MULX: begin
					if (mul_done) begin
						x_q      <= prod_cap;
						issued_q <= 1'b0;
						state_q  <= S_MULY;
					end
				end
				S_MULY: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						if (slope_q) begin
							slope_sum_q <= sat_add(slope_sum_q, term);
							state_q     <= S_DONE;
						end else begin
							value_sum_q <= sat_add(value_sum_q, term);
							state_q     <= ent_q.func ? S_DONE : S_DIVR;
						end
					end
				end
				S_DIVR: begin
					if (div_done) begin
						r_q      <= div_q;
						issued_q <= 1'b0;
						state_q  <= S_DIVV;
					end
				end
				S_DIVV: begin
					if (div_done) begin
						v_q      <= div_q;
						slope_q  <= 1'b1;
						issued_q <= 1'b0;
						state_q  <= S_MULX;
					end
				end
				S_DONE: begin
					if (!ent_q.last) begin
						state_q <= S_IDLE;
					end else if (!res_valid_q) begin
						value_q     <= clip_v[31:0];
						slope_q_out <= ent_q.func ? 32'sd0 : clip_s[31:0];
						sat_q       <= clip_v[32] || (!ent_q.func && clip_s[32]);
						res_valid_q <= 1'b1;
						value_sum_q <= '0;
						slope_sum_q <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> issued_q)
		else $error("multiplier finished with no operation outstanding");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> issued_q)
		else $error("divider finished with no operation outstanding");

	a_offdiag_slope_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_q.func && (state_q != S_DONE)) |=> $stable(slope_sum_q))
		else $error("off-diagonal term changed the slope sum");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (res_valid_q && (value_sum_q == 64'sd0) && (slope_sum_q == 64'sd0)))
		else $error("sums not cleared after a result was issued");

endmodule

### hw/rtl/plasmon_pole_self_energy_accumulator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         push / full           func .. last
// result    out        empty / pop           sigma_value, sigma_slope, saturated
// config    in         cfg_valid / cfg_ready broadening
//
// A skipped term passes the back end with no arithmetic; diagonal and off-diagonal terms
// wait on the shared divider, which retires one quotient bit per cycle, and on the 64x64
// multiply built from four 32x32 products.
// Reset clears the sums, the broadening register, the input queue and the result register; no clearing pass.
// Two requests queue ahead of the back end, and one result waits in its output register.
// A result waiting to be popped stalls only the back end on the next last term.

module plasmon_pole_self_energy_accumulator #(
	parameter int FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic signed [31:0]  freq_a,
	input  logic signed [31:0]  freq_b,
	input  logic signed [31:0]  band_energy,
	input  logic                occupied,
	input  logic signed [31:0]  pole_freq,
	input  logic signed [31:0]  pole_weight,
	input  logic signed [31:0]  elem_a,
	input  logic signed [31:0]  elem_b,
	input  logic                last,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  sigma_value,
	output logic signed [31:0]  sigma_slope,
	output logic                saturated,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [30:0]         broadening
);

	logic [30:0]     broadening_q;
	logic            take;
	logic            avail;
	ppsa_pkg::term_t ent;
	logic            res_valid;

	assign cfg_ready = 1'b1;
	assign empty     = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			broadening_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			broadening_q <= broadening;
		end
	end

	ppsa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.freq_a      (freq_a),
		.freq_b      (freq_b),
		.band_energy (band_energy),
		.occupied    (occupied),
		.pole_freq   (pole_freq),
		.pole_weight (pole_weight),
		.elem_a      (elem_a),
		.elem_b      (elem_b),
		.last        (last),
		.take        (take),
		.avail       (avail),
		.ent         (ent)
	);

	ppsa_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.eta         (broadening_q),
		.avail       (avail),
		.ent         (ent),
		.take        (take),
		.res_valid   (res_valid),
		.res_pop     (pop),
		.sigma_value (sigma_value),
		.sigma_slope (sigma_slope),
		.saturated   (saturated)
	);

endmodule
